@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ rtl/ssoc_pkg.sv @@
// ----------------------------------------------------------------------------
// ssoc_pkg
// Shared types and constants for the straight segment overlap counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ssoc_pkg;

    localparam int COORD_W    = 10;
    localparam int COORD_SPAN = 1 << COORD_W;
    localparam int COUNT_W    = 21;

    localparam logic [1:0]         COVER_SAT = 2'd2;
    localparam logic [COUNT_W-1:0] TOTAL_MAX = {COUNT_W{1'b1}};

    typedef logic [COORD_W-1:0] coord_t;

    // input transaction, last field (start_x) in the low bits
    typedef struct packed {
        coord_t end_y;
        coord_t end_x;
        coord_t start_y;
        coord_t start_x;
    } seg_t;

    // result transaction, padded to whole bytes
    typedef struct packed {
        logic [1:0]         pad;
        logic [COUNT_W-1:0] overlap_count;
        logic               accepted;
    } res_t;

    // controller -> datapath
    typedef struct packed {
        logic clear;
        logic load;
        logic draw;
        logic emit;
    } ssoc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic in_ok;
        logic draw_last;
    } ssoc_sts_t;

endpackage

@@ rtl/straight_segment_overlap_counter.sv @@
// A straight segment is accepted, walked one cell at a time, flushed and
// handed off; a rejected one goes straight to the hand-off. One segment is in
// flight at a time, with one coverage read-modify-write per cell through the
// single-write-port coverage memory; the result waits while m_tready is low.
// Reset: clearing pass over all 2^(2*ceil(log2(min(GRID_SIDE,1024)))) memory
// words, 1048576 at the default size, with s_tready low until it completes.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// straight_segment_overlap_counter
// Rasterizes axis-aligned segments and counts cells covered two or more times.
// ----------------------------------------------------------------------------

module straight_segment_overlap_counter
    import ssoc_pkg::*;
#(
    parameter int GRID_SIDE = 1024
)(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // start_x, start_y, end_x, end_y
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // accepted, overlap_count, zero pad
);

    ssoc_cmd_t cmd;
    ssoc_sts_t sts;
    res_t      res;

    ssoc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    ssoc_datapath #(
        .GRID_SIDE (GRID_SIDE)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .seg     (seg_t'(s_tdata)),
        .res     (res)
    );

    assign m_tdata = res;

    // one segment at a time
    `ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // no intake during the clearing pass
    `ASSERT_IMPLIES(a_no_accept_clear, aclk, aresetn, cmd.clear, !s_tready)
    // a result appears only after the hand-off command
    `ASSERT_IMPLIES(a_result_src, aclk, aresetn, $rose(m_tvalid), $past(cmd.emit))

endmodule

@@ rtl/ssoc_ctrl.sv @@
// ----------------------------------------------------------------------------
// ssoc_ctrl
// Sequencer: clearing pass, segment intake, cell walk, result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssoc_ctrl
    import ssoc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output ssoc_cmd_t cmd,
    input  ssoc_sts_t sts
);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_DRAW  = 5'b00100,
        ST_FLUSH = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_tready     = 1'b0;
        m_valid_next = m_valid_reg & ~m_tready;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = sts.in_ok ? ST_DRAW : ST_DONE;
                end
            end
            ST_DRAW: begin
                cmd.draw = 1'b1;
                if (sts.draw_last) begin
                    state_next = ST_FLUSH;
                end
            end
            // last cell write-back completes here
            ST_FLUSH: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.emit     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule

@@ rtl/ssoc_datapath.sv @@
// ----------------------------------------------------------------------------
// ssoc_datapath
// Segment decode, coverage memory with read-modify-write pipe, overlap total.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssoc_datapath
    import ssoc_pkg::*;
#(
    parameter int GRID_SIDE = 1024
)(
    input  logic      aclk,
    input  logic      aresetn,
    input  ssoc_cmd_t cmd,
    output ssoc_sts_t sts,
    input  seg_t      seg,
    output res_t      res
);

    // coordinates never exceed the field range, so larger grids add no cells
    localparam int USED_SIDE = (GRID_SIDE < COORD_SPAN) ? GRID_SIDE : COORD_SPAN;
    localparam int CW        = $clog2(USED_SIDE);
    localparam int AW        = 2 * CW;
    localparam int DEPTH     = 1 << AW;

    logic [1:0]         mem [DEPTH];

    logic               acc_reg;
    logic               vert_reg;
    logic [CW-1:0]      fix_reg;
    logic [CW-1:0]      k_reg;
    logic [CW-1:0]      hi_reg;
    logic [AW-1:0]      clr_addr_reg;
    logic               rd_valid_reg;
    logic [AW-1:0]      wr_addr_reg;
    logic [1:0]         rd_data_reg;
    logic [COUNT_W-1:0] total_reg;
    res_t               res_reg;

    logic               vert, horiz, on_grid;
    coord_t             a_c, b_c, lo_c, hi_c, fix_c;
    logic [AW-1:0]      rd_addr;
    logic               bump, hit;
    logic [1:0]         cell_inc;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [1:0]         mem_wdata;

    always_comb begin
        vert    = (seg.start_x == seg.end_x);
        horiz   = (seg.start_y == seg.end_y);
        on_grid = (32'(seg.start_x) < GRID_SIDE) && (32'(seg.start_y) < GRID_SIDE) &&
                  (32'(seg.end_x)   < GRID_SIDE) && (32'(seg.end_y)   < GRID_SIDE);
        a_c     = vert ? seg.start_y : seg.start_x;
        b_c     = vert ? seg.end_y   : seg.end_x;
        lo_c    = (a_c < b_c) ? a_c : b_c;
        hi_c    = (a_c < b_c) ? b_c : a_c;
        fix_c   = vert ? seg.start_x : seg.start_y;
    end

    // cell (x, y) lives at {y, x}
    assign rd_addr = vert_reg ? {k_reg, fix_reg} : {fix_reg, k_reg};

    assign cell_inc  = rd_data_reg + 2'd1;
    assign bump      = rd_valid_reg && (rd_data_reg < COVER_SAT);
    assign hit       = bump && (cell_inc == COVER_SAT);

    assign mem_we    = cmd.clear | bump;
    assign mem_waddr = cmd.clear ? clr_addr_reg : wr_addr_reg;
    assign mem_wdata = cmd.clear ? 2'd0 : cell_inc;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.draw) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            rd_valid_reg <= 1'b0;
            total_reg    <= '0;
        end else begin
            if (cmd.clear) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            rd_valid_reg <= cmd.draw;
            if (hit && (total_reg != TOTAL_MAX)) begin
                total_reg <= total_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            acc_reg  <= sts.in_ok;
            vert_reg <= vert;
            fix_reg  <= fix_c[CW-1:0];
            k_reg    <= lo_c[CW-1:0];
            hi_reg   <= hi_c[CW-1:0];
        end else if (cmd.draw) begin
            k_reg    <= k_reg + 1'b1;
        end
        wr_addr_reg <= rd_addr;
        if (cmd.emit) begin
            res_reg.pad           <= '0;
            res_reg.overlap_count <= total_reg;
            res_reg.accepted      <= acc_reg;
        end
    end

    assign sts.clr_last  = &clr_addr_reg;
    assign sts.in_ok     = (vert || horiz) && on_grid;
    assign sts.draw_last = (k_reg == hi_reg);
    assign res           = res_reg;

endmodule
